// File: sv/turtle_pkg.sv
// Shared types, widths and fixed-point helpers for the 3D turtle.
// Used by turtle_ctrl, turtle_dp and turtle_3d_interpreter.
package turtle_pkg;

    localparam int POS_W  = 32;
    localparam int VEC_W  = 18;
    localparam int MA_W   = 38;
    localparam int MB_W   = 19;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int D_W    = 21;
    localparam int T_W    = 24;
    localparam int CR_W   = 37;
    localparam int FRAC_W = 16;
    localparam int STEP_W = 5;
    localparam int NUM_VEC = 4;
    localparam int FRAME_W = 3 * POS_W + 3 * NUM_VEC * VEC_W;

    localparam logic [STEP_W-1:0] MOVE_LAST_STEP = 5'd3;
    localparam logic [STEP_W-1:0] ROT_LAST_STEP  = 5'd20;
    localparam logic [1:0]        ROT_LAST_PASS  = 2'd2;

    localparam logic signed [ACC_W-1:0] HALF_LSB = 58'sd32768;
    localparam logic signed [ACC_W-1:0] VEC_MAX  = 58'sd131071;
    localparam logic signed [ACC_W-1:0] VEC_MIN  = -58'sd131072;
    localparam logic signed [ACC_W-1:0] POS_MAX  = 58'sd2147483647;
    localparam logic signed [ACC_W-1:0] POS_MIN  = -58'sd2147483648;
    localparam logic signed [MB_W-1:0]  ONE_Q16  = 19'sd65536;

    typedef enum logic [2:0] {
        MODE_NOP, MODE_MOVE_DRAW, MODE_MOVE, MODE_ROT_X,
        MODE_ROT_Y, MODE_ROT_Z, MODE_PUSH, MODE_POP
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK, STATUS_PUSH_FULL, STATUS_POP_EMPTY
    } status_t;

    typedef enum logic [2:0] {
        OP_IDLE, OP_LOAD, OP_MOVE, OP_ROT, OP_PUSH, OP_POP_RD, OP_POP_LD, OP_RESULT
    } dp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECODE, ST_MOVE, ST_ROT, ST_PUSH, ST_POP_RD, ST_POP_LD, ST_FINISH
    } state_t;

    typedef struct packed {
        dp_op_t            op;
        logic [STEP_W-1:0] step;
        logic [1:0]        vsel;
    } dp_cmd_t;

    typedef struct packed {
        mode_t   mode;
        status_t status;
    } dp_stat_t;

    function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] x);
        rnd16 = (x + HALF_LSB) >>> FRAC_W;
    endfunction

    function automatic logic signed [VEC_W-1:0] sat_vec(input logic signed [ACC_W-1:0] x);
        if (x > VEC_MAX)
            sat_vec = VEC_MAX[VEC_W-1:0];
        else if (x < VEC_MIN)
            sat_vec = VEC_MIN[VEC_W-1:0];
        else
            sat_vec = x[VEC_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] x);
        if (x > POS_MAX)
            sat_pos = POS_MAX[POS_W-1:0];
        else if (x < POS_MIN)
            sat_pos = POS_MIN[POS_W-1:0];
        else
            sat_pos = x[POS_W-1:0];
    endfunction

endpackage

// File: sv/turtle_ctrl.sv
// Sequencer for the 3D turtle: handshakes, step and pass counters.
// Depends on turtle_pkg; drives turtle_dp through a dp_cmd_t.
module turtle_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  turtle_pkg::dp_stat_t stat,
    output turtle_pkg::dp_cmd_t  cmd
);

    localparam logic [turtle_pkg::STEP_W-1:0] MOVE_LAST = turtle_pkg::MOVE_LAST_STEP;
    localparam logic [turtle_pkg::STEP_W-1:0] ROT_LAST  = turtle_pkg::ROT_LAST_STEP;

    turtle_pkg::state_t state_reg, state_next;
    logic [turtle_pkg::STEP_W-1:0] step_reg, step_next;
    logic [1:0] pass_reg, pass_next;
    logic out_valid_reg, out_valid_next;
    logic [1:0] vsel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= turtle_pkg::ST_IDLE;
            step_reg      <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // target vector per pass: heading, then the two axes other than the pivot
    always_comb
    begin
        unique case (pass_reg)
            2'd0:    vsel = 2'd0;
            2'd1:    vsel = (stat.mode == turtle_pkg::MODE_ROT_X) ? 2'd2 : 2'd1;
            default: vsel = (stat.mode == turtle_pkg::MODE_ROT_Z) ? 2'd2 : 2'd3;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = turtle_pkg::OP_IDLE;
        cmd.step       = step_reg;
        cmd.vsel       = vsel;
        unique case (state_reg)
            turtle_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = turtle_pkg::OP_LOAD;
                    state_next = turtle_pkg::ST_DECODE;
                end
            end
            turtle_pkg::ST_DECODE:
            begin
                step_next = '0;
                pass_next = '0;
                priority if (stat.status != turtle_pkg::STATUS_OK)
                    state_next = turtle_pkg::ST_FINISH;
                else if (stat.mode == turtle_pkg::MODE_MOVE_DRAW
                         || stat.mode == turtle_pkg::MODE_MOVE)
                    state_next = turtle_pkg::ST_MOVE;
                else if (stat.mode == turtle_pkg::MODE_ROT_X
                         || stat.mode == turtle_pkg::MODE_ROT_Y
                         || stat.mode == turtle_pkg::MODE_ROT_Z)
                    state_next = turtle_pkg::ST_ROT;
                else if (stat.mode == turtle_pkg::MODE_PUSH)
                    state_next = turtle_pkg::ST_PUSH;
                else if (stat.mode == turtle_pkg::MODE_POP)
                    state_next = turtle_pkg::ST_POP_RD;
                else
                    state_next = turtle_pkg::ST_FINISH;
            end
            turtle_pkg::ST_MOVE:
            begin
                cmd.op    = turtle_pkg::OP_MOVE;
                step_next = step_reg + 1'b1;
                if (step_reg == MOVE_LAST)
                    state_next = turtle_pkg::ST_FINISH;
            end
            turtle_pkg::ST_ROT:
            begin
                cmd.op    = turtle_pkg::OP_ROT;
                step_next = step_reg + 1'b1;
                if (step_reg == ROT_LAST)
                begin
                    step_next = '0;
                    pass_next = pass_reg + 1'b1;
                    if (pass_reg == turtle_pkg::ROT_LAST_PASS)
                        state_next = turtle_pkg::ST_FINISH;
                end
            end
            turtle_pkg::ST_PUSH:
            begin
                cmd.op     = turtle_pkg::OP_PUSH;
                state_next = turtle_pkg::ST_FINISH;
            end
            turtle_pkg::ST_POP_RD:
            begin
                cmd.op     = turtle_pkg::OP_POP_RD;
                state_next = turtle_pkg::ST_POP_LD;
            end
            turtle_pkg::ST_POP_LD:
            begin
                cmd.op     = turtle_pkg::OP_POP_LD;
                state_next = turtle_pkg::ST_FINISH;
            end
            turtle_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = turtle_pkg::OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = turtle_pkg::ST_IDLE;
                end
            end
            default:
                state_next = turtle_pkg::ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sv/turtle_dp.sv
// Datapath for the 3D turtle: frame registers, one shared multiplier with
// accumulator, frame stack memory and result registers. Depends on turtle_pkg.
module turtle_dp #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  turtle_pkg::dp_cmd_t        cmd,
    output turtle_pkg::dp_stat_t       stat,
    input  logic [2:0]                 mode,
    input  logic signed [31:0]         distance,
    input  logic signed [17:0]         cos_angle,
    input  logic signed [17:0]         sin_angle,
    output logic signed [31:0]         start_x,
    output logic signed [31:0]         start_y,
    output logic signed [31:0]         start_z,
    output logic signed [31:0]         end_x,
    output logic signed [31:0]         end_y,
    output logic signed [31:0]         end_z,
    output logic                       draw_valid,
    output logic [1:0]                 status
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int POS_W  = turtle_pkg::POS_W;
    localparam int VEC_W  = turtle_pkg::VEC_W;
    localparam int ACC_W  = turtle_pkg::ACC_W;
    localparam int FRAME_W = turtle_pkg::FRAME_W;

    turtle_pkg::mode_t   mode_reg;
    turtle_pkg::status_t status_reg;
    logic signed [POS_W-1:0] dist_reg;
    logic signed [VEC_W-1:0] cos_reg, sin_reg;

    logic signed [POS_W-1:0] pos_reg [3];
    logic signed [VEC_W-1:0] vec_reg [turtle_pkg::NUM_VEC][3];
    logic [CNT_W-1:0] count_reg;

    logic signed [turtle_pkg::MA_W-1:0] mul_a;
    logic signed [turtle_pkg::MB_W-1:0] mul_b;
    logic signed [turtle_pkg::PROD_W-1:0] prod_reg;
    turtle_pkg::dp_cmd_t cmd_d_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [turtle_pkg::D_W-1:0] d_reg;
    logic signed [turtle_pkg::T_W-1:0] t_reg;
    logic signed [turtle_pkg::CR_W-1:0] cr_reg [3];
    logic signed [VEC_W-1:0] r_reg [3];
    logic signed [POS_W-1:0] seg_start_reg [3];

    logic [FRAME_W-1:0] mem [STACK_DEPTH];
    logic [FRAME_W-1:0] rd_reg;
    logic [FRAME_W-1:0] wr_frame;

    logic signed [POS_W-1:0] out_start_reg [3];
    logic signed [POS_W-1:0] out_end_reg [3];
    logic draw_reg;
    turtle_pkg::status_t out_status_reg;

    logic [1:0] ax;
    logic signed [VEC_W-1:0] kv [3];
    logic signed [VEC_W-1:0] vv [3];
    logic signed [turtle_pkg::MB_W-1:0] oc;
    logic signed [ACC_W-1:0] pe;
    logic signed [ACC_W-1:0] acc_sum;
    logic [CNT_W-1:0] cnt_dec;
    logic full, empty;
    turtle_pkg::mode_t in_mode;

    assign in_mode = turtle_pkg::mode_t'(mode);
    assign full    = (count_reg == CNT_W'(STACK_DEPTH));
    assign empty   = (count_reg == '0);
    assign cnt_dec = count_reg - 1'b1;
    assign stat.mode   = mode_reg;
    assign stat.status = status_reg;

    always_comb
    begin
        unique case (mode_reg)
            turtle_pkg::MODE_ROT_Y: ax = 2'd2;
            turtle_pkg::MODE_ROT_Z: ax = 2'd3;
            default:                ax = 2'd1;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            kv[i] = vec_reg[ax][i];
            vv[i] = vec_reg[cmd.vsel][i];
        end
    end

    assign oc = turtle_pkg::ONE_Q16 - turtle_pkg::MB_W'(cos_reg);

    // operand select for the step being issued
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.op == turtle_pkg::OP_MOVE)
        begin
            if (cmd.step < 5'd3)
            begin
                mul_a = turtle_pkg::MA_W'(dist_reg);
                mul_b = turtle_pkg::MB_W'(vec_reg[0][cmd.step[1:0]]);
            end
        end
        else if (cmd.op == turtle_pkg::OP_ROT)
        begin
            unique case (cmd.step)
                5'd0:  begin mul_a = turtle_pkg::MA_W'(kv[0]); mul_b = turtle_pkg::MB_W'(vv[0]); end
                5'd1:  begin mul_a = turtle_pkg::MA_W'(kv[1]); mul_b = turtle_pkg::MB_W'(vv[1]); end
                5'd2:  begin mul_a = turtle_pkg::MA_W'(kv[2]); mul_b = turtle_pkg::MB_W'(vv[2]); end
                5'd3:  begin mul_a = turtle_pkg::MA_W'(kv[1]); mul_b = turtle_pkg::MB_W'(vv[2]); end
                5'd4:  begin mul_a = turtle_pkg::MA_W'(d_reg); mul_b = oc; end
                5'd5:  begin mul_a = turtle_pkg::MA_W'(kv[2]); mul_b = turtle_pkg::MB_W'(vv[1]); end
                5'd6:  begin mul_a = turtle_pkg::MA_W'(kv[2]); mul_b = turtle_pkg::MB_W'(vv[0]); end
                5'd7:  begin mul_a = turtle_pkg::MA_W'(kv[0]); mul_b = turtle_pkg::MB_W'(vv[2]); end
                5'd8:  begin mul_a = turtle_pkg::MA_W'(kv[0]); mul_b = turtle_pkg::MB_W'(vv[1]); end
                5'd9:  begin mul_a = turtle_pkg::MA_W'(kv[1]); mul_b = turtle_pkg::MB_W'(vv[0]); end
                5'd10: begin mul_a = turtle_pkg::MA_W'(cr_reg[0]); mul_b = turtle_pkg::MB_W'(sin_reg); end
                5'd11: begin mul_a = turtle_pkg::MA_W'(vv[0]); mul_b = turtle_pkg::MB_W'(cos_reg); end
                5'd12: begin mul_a = turtle_pkg::MA_W'(t_reg); mul_b = turtle_pkg::MB_W'(kv[0]); end
                5'd13: begin mul_a = turtle_pkg::MA_W'(cr_reg[1]); mul_b = turtle_pkg::MB_W'(sin_reg); end
                5'd14: begin mul_a = turtle_pkg::MA_W'(vv[1]); mul_b = turtle_pkg::MB_W'(cos_reg); end
                5'd15: begin mul_a = turtle_pkg::MA_W'(t_reg); mul_b = turtle_pkg::MB_W'(kv[1]); end
                5'd16: begin mul_a = turtle_pkg::MA_W'(cr_reg[2]); mul_b = turtle_pkg::MB_W'(sin_reg); end
                5'd17: begin mul_a = turtle_pkg::MA_W'(vv[2]); mul_b = turtle_pkg::MB_W'(cos_reg); end
                5'd18: begin mul_a = turtle_pkg::MA_W'(t_reg); mul_b = turtle_pkg::MB_W'(kv[2]); end
                default: ;
            endcase
        end
    end

    assign pe      = ACC_W'(prod_reg);
    assign acc_sum = acc_reg + pe;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // accumulate stage, in the cycle after issue
    always_ff @(posedge clk)
    begin
        if (cmd_d_reg.op == turtle_pkg::OP_ROT)
        begin
            unique case (cmd_d_reg.step)
                5'd0, 5'd3, 5'd6, 5'd8: acc_reg <= pe;
                5'd1, 5'd11, 5'd14, 5'd17: acc_reg <= acc_sum;
                5'd2:
                begin
                    acc_reg <= acc_sum;
                    d_reg   <= turtle_pkg::D_W'(turtle_pkg::rnd16(acc_sum));
                end
                5'd4:  t_reg <= turtle_pkg::T_W'(turtle_pkg::rnd16(pe));
                5'd5:  cr_reg[0] <= turtle_pkg::CR_W'(acc_reg - pe);
                5'd7:  cr_reg[1] <= turtle_pkg::CR_W'(acc_reg - pe);
                5'd9:  cr_reg[2] <= turtle_pkg::CR_W'(acc_reg - pe);
                5'd10, 5'd13, 5'd16: acc_reg <= turtle_pkg::rnd16(pe);
                5'd12: r_reg[0] <= turtle_pkg::sat_vec(turtle_pkg::rnd16(acc_sum));
                5'd15: r_reg[1] <= turtle_pkg::sat_vec(turtle_pkg::rnd16(acc_sum));
                5'd18: r_reg[2] <= turtle_pkg::sat_vec(turtle_pkg::rnd16(acc_sum));
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            wr_frame[i*POS_W +: POS_W] = pos_reg[i];
        for (int j = 0; j < turtle_pkg::NUM_VEC; j++)
            for (int i = 0; i < 3; i++)
                wr_frame[3*POS_W + (j*3+i)*VEC_W +: VEC_W] = vec_reg[j][i];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == turtle_pkg::OP_PUSH)
            mem[count_reg[ADDR_W-1:0]] <= wr_frame;
        if (cmd.op == turtle_pkg::OP_POP_RD)
            rd_reg <= mem[cnt_dec[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == turtle_pkg::OP_LOAD)
        begin
            dist_reg <= distance;
            cos_reg  <= cos_angle;
            sin_reg  <= sin_angle;
        end
        if (cmd.op == turtle_pkg::OP_MOVE && cmd.step == '0)
            seg_start_reg <= pos_reg;
        if (cmd.op == turtle_pkg::OP_RESULT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_start_reg[i] <= draw_reg ? seg_start_reg[i] : '0;
                out_end_reg[i]   <= draw_reg ? pos_reg[i] : '0;
            end
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= turtle_pkg::MODE_NOP;
            status_reg <= turtle_pkg::STATUS_OK;
            draw_reg   <= 1'b0;
            cmd_d_reg  <= '0;
            count_reg  <= '0;
            for (int i = 0; i < 3; i++)
                pos_reg[i] <= '0;
            for (int j = 0; j < turtle_pkg::NUM_VEC; j++)
                for (int i = 0; i < 3; i++)
                    vec_reg[j][i] <= '0;
            vec_reg[0][1] <= VEC_W'(turtle_pkg::ONE_Q16);
            vec_reg[1][0] <= VEC_W'(turtle_pkg::ONE_Q16);
            vec_reg[2][1] <= VEC_W'(turtle_pkg::ONE_Q16);
            vec_reg[3][2] <= VEC_W'(turtle_pkg::ONE_Q16);
        end
        else
        begin
            cmd_d_reg <= cmd;
            if (cmd.op == turtle_pkg::OP_LOAD)
            begin
                mode_reg <= in_mode;
                draw_reg <= (in_mode == turtle_pkg::MODE_MOVE_DRAW);
                if (in_mode == turtle_pkg::MODE_PUSH && full)
                    status_reg <= turtle_pkg::STATUS_PUSH_FULL;
                else if (in_mode == turtle_pkg::MODE_POP && empty)
                    status_reg <= turtle_pkg::STATUS_POP_EMPTY;
                else
                    status_reg <= turtle_pkg::STATUS_OK;
            end
            if (cmd_d_reg.op == turtle_pkg::OP_MOVE && cmd_d_reg.step < 5'd3)
                pos_reg[cmd_d_reg.step[1:0]] <= turtle_pkg::sat_pos(
                    ACC_W'(pos_reg[cmd_d_reg.step[1:0]]) + turtle_pkg::rnd16(pe));
            if (cmd.op == turtle_pkg::OP_ROT && cmd.step == turtle_pkg::ROT_LAST_STEP)
                for (int i = 0; i < 3; i++)
                    vec_reg[cmd.vsel][i] <= r_reg[i];
            if (cmd.op == turtle_pkg::OP_PUSH)
                count_reg <= count_reg + 1'b1;
            if (cmd.op == turtle_pkg::OP_POP_RD)
                count_reg <= cnt_dec;
            if (cmd.op == turtle_pkg::OP_POP_LD)
            begin
                for (int i = 0; i < 3; i++)
                    pos_reg[i] <= rd_reg[i*POS_W +: POS_W];
                for (int j = 0; j < turtle_pkg::NUM_VEC; j++)
                    for (int i = 0; i < 3; i++)
                        vec_reg[j][i] <= rd_reg[3*POS_W + (j*3+i)*VEC_W +: VEC_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            draw_valid <= 1'b0;
        else if (cmd.op == turtle_pkg::OP_RESULT)
            draw_valid <= draw_reg;
    end

    assign start_x = out_start_reg[0];
    assign start_y = out_start_reg[1];
    assign start_z = out_start_reg[2];
    assign end_x   = out_end_reg[0];
    assign end_y   = out_end_reg[1];
    assign end_z   = out_end_reg[2];
    assign status  = out_status_reg;

endmodule

// File: sv/turtle_3d_interpreter.sv
// 3D turtle interpreter, top level: joins turtle_ctrl and turtle_dp.
// Depends on turtle_pkg, turtle_ctrl, turtle_dp.
//
// One command is taken at a time and gives exactly one result beat. A move
// sends three products through the single multiplier, and a rotation
// turns three vectors of 21 steps each, bound by the one 38x19 multiplier
// feeding the accumulator. A finished result sits in the output register,
// so the next command is accepted while it waits to be taken. Frames are
// saved in a STACK_DEPTH-row memory; push on a full stack and pop on an
// empty one report a status and change nothing.
module turtle_3d_interpreter #(
    parameter int STACK_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         mode,
    input  logic signed [31:0] distance,
    input  logic signed [17:0] cos_angle,
    input  logic signed [17:0] sin_angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] start_x,
    output logic signed [31:0] start_y,
    output logic signed [31:0] start_z,
    output logic signed [31:0] end_x,
    output logic signed [31:0] end_y,
    output logic signed [31:0] end_z,
    output logic               draw_valid,
    output logic [1:0]         status
);

    turtle_pkg::dp_cmd_t  cmd;
    turtle_pkg::dp_stat_t stat;

    turtle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    turtle_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .mode       (mode),
        .distance   (distance),
        .cos_angle  (cos_angle),
        .sin_angle  (sin_angle),
        .start_x    (start_x),
        .start_y    (start_y),
        .start_z    (start_z),
        .end_x      (end_x),
        .end_y      (end_y),
        .end_z      (end_z),
        .draw_valid (draw_valid),
        .status     (status)
    );

endmodule

// File: tb/turtle_3d_interpreter_tb.sv
// Self-checking testbench for turtle_3d_interpreter: directed and random turtle commands.
// Depends on turtle_pkg and the turtle_3d_interpreter RTL; predicts each result beat in SV.
module turtle_3d_interpreter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] distance;
        logic signed [17:0] cos_angle;
        logic signed [17:0] sin_angle;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] sx, sy, sz, ex, ey, ez;
        logic               draw;
        logic [1:0]         status;
    } seg_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [2:0] mode;
    logic signed [31:0] distance;
    logic signed [17:0] cos_angle, sin_angle;
    logic signed [31:0] start_x, start_y, start_z, end_x, end_y, end_z;
    logic draw_valid;
    logic [1:0] status;

    turtle_3d_interpreter #(.STACK_DEPTH(DEPTH)) u_top (.*);

    cmd_t   cmd_q[$];
    seg_t   seg_q[$];
    int     errors = 0;
    longint cycles = 0;
    bit     hold_off = 0;
    int     in_gap = 0, out_gap = 0;

    // predicted turtle state
    longint pos[3];
    longint vecs[4][3];  // heading, x, y, z axes
    longint st_pos[DEPTH][3];
    longint st_vec[DEPTH][4][3];
    int     depth_cnt;

    function automatic longint rnd(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void queue_cmd(input logic [2:0] m, logic signed [31:0] d,
                                      logic signed [17:0] ca, logic signed [17:0] sa);
        cmd_t c;
        c.mode      = m;
        c.distance  = d;
        c.cos_angle = ca;
        c.sin_angle = sa;
        cmd_q = {cmd_q, c};
    endfunction

    function automatic void turn(ref longint v[3], input longint k[3], longint c, longint s);
        longint d, t, cr[3], r[3];
        d = rnd(k[0]*v[0] + k[1]*v[1] + k[2]*v[2]);
        t = rnd(d * (65536 - c));
        cr[0] = k[1]*v[2] - k[2]*v[1];
        cr[1] = k[2]*v[0] - k[0]*v[2];
        cr[2] = k[0]*v[1] - k[1]*v[0];
        for (int i = 0; i < 3; i++)
            r[i] = clip(rnd(v[i]*c + rnd(cr[i]*s) + k[i]*t), -131072, 131071);
        v = r;
    endfunction

    function automatic seg_t predict_step(cmd_t cm);
        seg_t r;
        longint k[3], np;
        int a;
        r = '0;
        case (turtle_pkg::mode_t'(cm.mode))
            turtle_pkg::MODE_MOVE_DRAW, turtle_pkg::MODE_MOVE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    np = clip(pos[i] + rnd(longint'(cm.distance) * vecs[0][i]),
                              -64'sd2147483648, 64'sd2147483647);
                    if (cm.mode == turtle_pkg::MODE_MOVE_DRAW)
                    begin
                        if (i == 0) begin r.sx = 32'(pos[i]); r.ex = 32'(np); end
                        if (i == 1) begin r.sy = 32'(pos[i]); r.ey = 32'(np); end
                        if (i == 2) begin r.sz = 32'(pos[i]); r.ez = 32'(np); end
                    end
                    pos[i] = np;
                end
                r.draw = (cm.mode == turtle_pkg::MODE_MOVE_DRAW);
            end
            turtle_pkg::MODE_ROT_X, turtle_pkg::MODE_ROT_Y, turtle_pkg::MODE_ROT_Z:
            begin
                a = int'(cm.mode) - int'(turtle_pkg::MODE_ROT_X);
                k = vecs[a+1];
                for (int j = 0; j < 4; j++)
                    if (j != a + 1)
                        turn(vecs[j], k, longint'(cm.cos_angle), longint'(cm.sin_angle));
            end
            turtle_pkg::MODE_PUSH:
                if (depth_cnt >= DEPTH)
                    r.status = turtle_pkg::STATUS_PUSH_FULL;
                else
                begin
                    st_pos[depth_cnt] = pos;
                    st_vec[depth_cnt] = vecs;
                    depth_cnt++;
                end
            turtle_pkg::MODE_POP:
                if (depth_cnt == 0)
                    r.status = turtle_pkg::STATUS_POP_EMPTY;
                else
                begin
                    depth_cnt--;
                    pos = st_pos[depth_cnt];
                    vecs = st_vec[depth_cnt];
                end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [17:0] rand_vec();
        case ($urandom_range(0, 5))
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'sd131071;
            3: return 18'sh20000;
            default: return $signed(18'($urandom));
        endcase
    endfunction

    function automatic logic signed [31:0] rand_dist();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3: return $signed(32'($urandom));
            default: return $signed(32'($urandom_range(0, 20 << 16))) - (10 << 16);
        endcase
    endfunction

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            mode <= '0; distance <= '0; cos_angle <= '0; sin_angle <= '0;
            in_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                seg_q = {seg_q, predict_step({mode, distance, cos_angle, sin_angle})};
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0 || cmd_q.size() == 0)
                begin
                    in_valid <= 0;
                    if (in_gap > 0) in_gap <= in_gap - 1;
                end
                else
                begin
                    cmd_t c;
                    c = cmd_q.pop_front();
                    in_valid <= 1;
                    mode <= c.mode; distance <= c.distance;
                    cos_angle <= c.cos_angle; sin_angle <= c.sin_angle;
                    in_gap <= pick_gap();
                end
            end
        end
    end

    // long receiver stall while the sender keeps offering beats
    initial
    begin
        wait (rst_n === 1'b1);
        repeat (3000) @(posedge clk);
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 0;
            out_gap <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (out_valid && out_ready)
            begin
                seg_t got, exp_s;
                got = {start_x, start_y, start_z, end_x, end_y, end_z, draw_valid, status};
                if (seg_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat %h", $realtime, got);
                end
                else
                begin
                    exp_s = seg_q.pop_front();
                    if (got !== exp_s)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %h actual %h", $realtime, exp_s, got);
                    end
                end
            end
            if (hold_off)
                out_ready <= 0;
            else if (out_gap > 0)
            begin
                out_ready <= 0;
                out_gap <= out_gap - 1;
            end
            else
            begin
                out_ready <= 1;
                out_gap <= pick_gap();
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL turtle_3d_interpreter");
                $finish;
            end
        end
    end

    initial
    begin
        cmd_t c;
        int p, n;
        pos = '{0, 0, 0};
        vecs = '{'{0, 65536, 0}, '{65536, 0, 0}, '{0, 65536, 0}, '{0, 0, 65536}};
        depth_cnt = 0;
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // directed
        queue_cmd(turtle_pkg::MODE_NOP, 32'sh7fffffff, 18'sh1ffff, 18'sh20000);
        queue_cmd(turtle_pkg::MODE_POP, '0, '0, '0);
        queue_cmd(turtle_pkg::MODE_MOVE_DRAW, 32'sh00010000, '0, '0);
        queue_cmd(turtle_pkg::MODE_MOVE, -32'sh00028000, '0, '0);
        queue_cmd(turtle_pkg::MODE_ROT_X, '0, '0, 18'sd65536);
        queue_cmd(turtle_pkg::MODE_ROT_Y, '0, 18'sd46341, 18'sd46341);
        queue_cmd(turtle_pkg::MODE_ROT_Z, '0, -18'sd65536, '0);
        queue_cmd(turtle_pkg::MODE_ROT_Z, '0, 18'sh1ffff, 18'sh1ffff);
        queue_cmd(turtle_pkg::MODE_ROT_X, '0, 18'sh20000, 18'sh20000);
        for (int i = 0; i < DEPTH + 1; i++)
            queue_cmd(turtle_pkg::MODE_PUSH, '0, '0, '0);
        queue_cmd(turtle_pkg::MODE_MOVE_DRAW, 32'sh7fffffff, '0, '0);
        queue_cmd(turtle_pkg::MODE_MOVE_DRAW, 32'sh7fffffff, '0, '0);
        queue_cmd(turtle_pkg::MODE_MOVE_DRAW, 32'sh80000000, '0, '0);
        for (int i = 0; i < DEPTH + 1; i++)
            queue_cmd(turtle_pkg::MODE_POP, '0, '0, '0);

        // random: bias toward moves and balanced push/pop
        n = 0;
        while (n < 1750)
        begin
            p = $urandom_range(0, 99);
            c.distance = rand_dist();
            c.cos_angle = rand_vec();
            c.sin_angle = rand_vec();
            if (p < 40)
                c.mode = ($urandom_range(0, 1)) ? turtle_pkg::MODE_MOVE_DRAW
                                                : turtle_pkg::MODE_MOVE;
            else if (p < 60) c.mode = 3'(turtle_pkg::MODE_ROT_X + $urandom_range(0, 2));
            else if (p < 75) c.mode = turtle_pkg::MODE_PUSH;
            else if (p < 90) c.mode = turtle_pkg::MODE_POP;
            else c.mode = 3'($urandom);
            cmd_q = {cmd_q, c};
            n++;
            if (cmd_q.size() > 20)
                wait (cmd_q.size() < 10);
        end

        wait (cmd_q.size() == 0 && !in_valid && seg_q.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && seg_q.size() == 0)
            $display("PASS turtle_3d_interpreter");
        else
            $display("FAIL turtle_3d_interpreter");
        $finish;
    end
endmodule

// File: sim.f
sv/turtle_pkg.sv
sv/turtle_ctrl.sv
sv/turtle_dp.sv
sv/turtle_3d_interpreter.sv
tb/turtle_3d_interpreter_tb.sv
